// ===== rtl/msbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Signature matcher package
// Shared constants, item codes and the structs passed between the front and
// back parts of the signature matcher.
// ----------------------------------------------------------------------------
package msbm_pkg;

	localparam int NUM_SIGS       = 16;
	localparam int MAX_SIG_LEN    = 64;
	localparam int MAX_FILE_BYTES = 16384;

	localparam int ENTRY_W  = 4;
	localparam int POS_W    = 6;
	localparam int LEN_W    = 7;
	localparam int CNT_W    = 15;
	localparam int OFS_W    = 14;
	localparam int SEL_W    = 5;
	localparam int ROW_W    = MAX_SIG_LEN * 8;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_WR_BYTE = 2'd0;
	localparam mode_t MODE_SET_LEN = 2'd1;
	localparam mode_t MODE_SCAN    = 2'd2;
	// Reserved code; such words are accepted and dropped.
	localparam mode_t MODE_NONE    = 2'd3;

	// Table write request from the front part.
	typedef struct packed {
		logic               sig_we;
		logic               len_we;
		logic [ENTRY_W-1:0] entry;
		logic [POS_W-1:0]   pos;
		logic [7:0]         data;
		logic [LEN_W-1:0]   len;
	} wr_t;

	// One queued file byte.
	typedef struct packed {
		logic [7:0] data;
		logic       fend;
	} scan_t;

endpackage

// ===== rtl/multi_signature_byte_matcher.sv =====
// ----------------------------------------------------------------------------
// Multi-signature byte matcher
// Searches a stream of file bytes for up to sixteen loaded byte signatures.
// ----------------------------------------------------------------------------
// Usage. Words enter on the s_ stream. s_tuser selects the kind: write one
// signature byte, set one signature length (zero empties the entry), or scan
// one file byte; s_tlast on a scan word marks the end of the file, so the
// next scan byte is at offset zero again. The cfg_ channel sets how many table
// entries, from entry zero, are searched; write it only while the block idles.
// Each scan byte yields zero to sixteen match words on the m_ stream in
// ascending entry order, m_tlast flagging the last one for that byte.
// Flow. A scan byte occupies the back part while it shifts the window, steps
// through the searched entries one by one with the single shared 64-byte
// comparator (the table memory reads one signature row per cycle unless the
// output stalls), and drains the last match; the next byte waits. A
// four-deep byte queue lets the input keep running while matching goes on.
// Load words wait until that queue is empty and the back part is idle, then
// take one cycle. When the receiver stalls, at most one finished match waits
// in the output register and one more in a holding register; the comparator
// then pauses and the queue fills before s_tready drops. Reset empties all
// entries, clears the window and offset and sets the searched count to zero.
// ----------------------------------------------------------------------------
module multi_signature_byte_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte [7:0], entry_index [11:8], byte_position [17:12],
	// entry_length [24:18], zero fill [31:25]
	input  logic [31:0] s_tdata,
	// mode [1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// start_offset [13:0], matched_entry [17:14], matched_length [24:18],
	// zero fill [31:25]
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import msbm_pkg::*;

	logic [SEL_W-1:0] in_use_q;
	logic             back_idle;
	logic             q_valid;
	logic             q_pop;
	scan_t            q_item;
	wr_t              wr;

	// The count register saturates at the table size.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cfg_valid) begin
			in_use_q <= (cfg_data > SEL_W'(NUM_SIGS)) ? SEL_W'(NUM_SIGS) : cfg_data;
		end
	end

	msbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.back_idle (back_idle),
		.wr        (wr),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	msbm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.in_use   (in_use_q),
		.idle     (back_idle),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// Table writes must never overlap a scan in progress.
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.sig_we || wr.len_we) |-> (back_idle && !q_valid))
		else $error("table write while a scan is in progress");

	// A reported match always carries a real signature length.
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:18] != 7'd0 && m_tdata[24:18] <= 7'(MAX_SIG_LEN)))
		else $error("match word with an impossible length");

	// The searched count never exceeds the table size.
	a_in_use_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= SEL_W'(NUM_SIGS))
		else $error("searched entry count out of range");
`endif

endmodule

// ===== rtl/msbm_front.sv =====
// ----------------------------------------------------------------------------
// Signature matcher front part
// Accepts input words, turns load words into table writes and queues scan
// bytes for the back part.
// ----------------------------------------------------------------------------
module msbm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,
	input  logic                  back_idle,
	output msbm_pkg::wr_t         wr,
	output logic                  q_valid,
	output msbm_pkg::scan_t       q_item,
	input  logic                  q_pop
);
	import msbm_pkg::*;

	localparam int QD = 4;

	scan_t      fifo_q [QD];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       accept;
	logic       push;
	logic [LEN_W-1:0] len_in;

	always_comb begin
		unique case (s_tuser)
			MODE_SCAN:    s_tready = (cnt_q != 3'(QD));
			MODE_WR_BYTE,
			MODE_SET_LEN: s_tready = back_idle && (cnt_q == 3'd0);
			default:      s_tready = 1'b1;
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign push   = accept && (s_tuser == MODE_SCAN);
	assign len_in = s_tdata[24:18];

	always_comb begin
		wr.sig_we = accept && (s_tuser == MODE_WR_BYTE);
		wr.len_we = accept && (s_tuser == MODE_SET_LEN);
		wr.data   = s_tdata[7:0];
		wr.entry  = s_tdata[11:8];
		wr.pos    = s_tdata[17:12];
		wr.len    = (len_in > LEN_W'(MAX_SIG_LEN)) ? LEN_W'(MAX_SIG_LEN) : len_in;
	end

	assign q_valid = (cnt_q != 3'd0);
	assign q_item  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{data: s_tdata[7:0], fend: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 2'd1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

endmodule

// ===== rtl/msbm_back.sv =====
// ----------------------------------------------------------------------------
// Signature matcher back part
// Holds the signature table and the byte window, checks one signature per
// cycle against the window unless the output stalls, and emits the match words.
// ----------------------------------------------------------------------------
module msbm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  msbm_pkg::wr_t              wr,
	input  logic                       q_valid,
	input  msbm_pkg::scan_t            q_item,
	output logic                       q_pop,
	input  logic [msbm_pkg::SEL_W-1:0] in_use,
	output logic                       idle,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,
	output logic                       m_tlast
);
	import msbm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	typedef struct packed {
		logic [OFS_W-1:0]   ofs;
		logic [ENTRY_W-1:0] entry;
		logic [LEN_W-1:0]   len;
	} res_t;

	state_t state_q;
	logic [ROW_W-1:0] sig_mem [NUM_SIGS];
	logic [LEN_W-1:0] len_q [NUM_SIGS];
	logic [ROW_W-1:0] win_q;
	logic [CNT_W-1:0] seen_q;
	logic             fend_q;
	logic [SEL_W-1:0] e_q;

	logic               valid_s1;
	logic [ENTRY_W-1:0] e_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [ROW_W-1:0]   sig_s1;

	res_t pend_q;
	logic pend_valid_q;
	res_t out_q;
	logic out_valid_q;
	logic out_last_q;

	logic [ROW_W-1:0] rev_win;
	logic [ROW_W-1:0] aligned;
	logic [5:0]       sh_amt;
	logic             eq;
	logic             hit_s1;
	logic             out_free;
	logic             adv;
	logic             issue;
	logic             last_issue;
	logic             finish;
	logic [CNT_W-1:0] ofs_full;
	res_t             new_res;

	// Oldest byte first, so a right shift lines the signature up with the
	// newest bytes of the window.
	always_comb begin
		for (int k = 0; k < MAX_SIG_LEN; k++) begin
			rev_win[k*8 +: 8] = win_q[(MAX_SIG_LEN-1-k)*8 +: 8];
		end
	end

	assign sh_amt  = 6'(7'(MAX_SIG_LEN) - len_s1);
	assign aligned = rev_win >> {sh_amt, 3'b000};

	always_comb begin
		eq = 1'b1;
		for (int j = 0; j < MAX_SIG_LEN; j++) begin
			if ((7'(j) < len_s1) && (aligned[j*8 +: 8] != sig_s1[j*8 +: 8])) begin
				eq = 1'b0;
			end
		end
	end

	assign hit_s1 = valid_s1 && (len_s1 != '0) && (CNT_W'(len_s1) <= seen_q) && eq;
	assign ofs_full = seen_q - CNT_W'(len_s1);
	assign new_res  = '{ofs: ofs_full[OFS_W-1:0], entry: e_s1, len: len_s1};

	assign out_free   = !out_valid_q || m_tready;
	assign adv        = !(hit_s1 && pend_valid_q && !out_free);
	assign issue      = (state_q == ST_SCAN) && adv;
	assign last_issue = issue && ((e_q + 5'd1) == in_use);
	assign finish     = (state_q == ST_FLUSH) && !valid_s1 && (!pend_valid_q || out_free);
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign idle       = (state_q == ST_IDLE);

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_q.len, out_q.entry, out_q.ofs};

	always_ff @(posedge clk) begin
		if (wr.sig_we) begin
			sig_mem[wr.entry][{wr.pos, 3'b000} +: 8] <= wr.data;
		end
		if (issue) begin
			sig_s1 <= sig_mem[e_q[ENTRY_W-1:0]];
			len_s1 <= len_q[e_q[ENTRY_W-1:0]];
			e_s1   <= e_q[ENTRY_W-1:0];
		end
		if (hit_s1 && adv) begin
			pend_q <= new_res;
		end
		if (hit_s1 && adv && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (finish && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			win_q        <= '0;
			seen_q       <= '0;
			fend_q       <= 1'b0;
			e_q          <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_SIGS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			if (wr.len_we) begin
				len_q[wr.entry] <= wr.len;
			end

			if (issue) begin
				valid_s1 <= 1'b1;
				e_q      <= e_q + 5'd1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			// A new word is loaded only when the register is free.
			if ((hit_s1 && adv && pend_valid_q) || (finish && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (hit_s1 && adv) begin
				pend_valid_q <= 1'b1;
			end else if (finish) begin
				pend_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (seen_q < CNT_W'(MAX_FILE_BYTES)) begin
							win_q   <= {win_q[ROW_W-9:0], q_item.data};
							seen_q  <= seen_q + 15'd1;
							fend_q  <= q_item.fend;
							e_q     <= '0;
							state_q <= (in_use == '0) ? ST_FLUSH : ST_SCAN;
						end else if (q_item.fend) begin
							seen_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (last_issue) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (finish) begin
						if (fend_q) begin
							seen_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
